/* hw/rtl/md5sh_pkg.sv */
// Package with the shared types, constants and step functions of the MD5 stream hasher.
`timescale 1ns / 1ps

package md5sh_pkg;

  localparam int unsigned MsgCountWidth = 61;
  localparam int unsigned WordAddrWidth = 4;
  localparam int unsigned WordCountWidth = 5;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  localparam logic [7:0] PadByte = 8'h80;
  // Highest fill that still leaves room for the length in the same block.
  localparam logic [5:0] LastShortFill = 6'd55;
  localparam logic [5:0] FullFill = 6'd63;
  localparam logic [3:0] LenLoWord = 4'd14;
  localparam logic [3:0] LenHiWord = 4'd15;
  localparam logic [WordCountWidth-1:0] LenLoCount = 5'd14;
  localparam logic [WordCountWidth-1:0] BlockWords = 5'd16;
  localparam logic [1:0] LastDigestWord = 2'd3;
  localparam logic [5:0] LastStep = 6'd63;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD_HEAD,
    ST_PAD_ZERO,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_CMP_LOAD,
    ST_CMP_STEP,
    ST_CMP_ADD,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RET_IDLE,
    RET_HEAD,
    RET_PAD2,
    RET_OUT
  } ret_e;

  typedef struct packed {
    logic take_byte;
    logic pad_head;
    logic pad_zero;
    logic len_lo;
    logic len_hi;
    logic wcnt_clr;
    logic cmp_load;
    logic cmp_step;
    logic cmp_add;
    logic out_next;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic [5:0]                fill;
    logic [WordCountWidth-1:0] wcnt;
    logic                      step_last;
  } dp_sts_t;

  function automatic logic [31:0] step_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'b0000: s = 5'd7;  4'b0001: s = 5'd12; 4'b0010: s = 5'd17; 4'b0011: s = 5'd22;
      4'b0100: s = 5'd5;  4'b0101: s = 5'd9;  4'b0110: s = 5'd14; 4'b0111: s = 5'd20;
      4'b1000: s = 5'd4;  4'b1001: s = 5'd11; 4'b1010: s = 5'd16; 4'b1011: s = 5'd23;
      4'b1100: s = 5'd6;  4'b1101: s = 5'd10; 4'b1110: s = 5'd15; 4'b1111: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word used by a step; the arithmetic wraps modulo 16.
  function automatic logic [3:0] word_sel(input logic [5:0] i);
    logic [3:0] ii;
    logic [3:0] g;
    ii = i[3:0];
    case (i[5:4])
      2'd0:    g = ii;
      2'd1:    g = 4'(ii * 4'd5 + 4'd1);
      2'd2:    g = 4'(ii * 4'd3 + 4'd5);
      2'd3:    g = 4'(ii * 4'd7);
      default: g = ii;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] round_fn(input logic [1:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (rnd)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      2'd3:    f = c ^ (b | ~d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

/* hw/rtl/md5sh_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module md5sh_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/md5sh_dp.sv */
// Datapath of the MD5 stream hasher: block store, byte count, chaining words and step logic.
`timescale 1ns / 1ps

module md5sh_dp
  import md5sh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  input  logic [7:0]  data_byte_i,
  output logic [31:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);

  logic [MsgCountWidth-1:0]  msg_q, msg_d;
  logic [WordCountWidth-1:0] wcnt_q, wcnt_d;
  logic [5:0]                step_q, step_d;
  logic [31:0]               wbuf_q, wbuf_d;
  logic [31:0]               chain_a_q, chain_b_q, chain_c_q, chain_d_q;
  logic [31:0]               chain_a_d, chain_b_d, chain_c_d, chain_d_d;
  logic [31:0]               wa_q, wb_q, wc_q, wd_q;
  logic [31:0]               wa_d, wb_d, wc_d, wd_d;

  logic [5:0]  fill;
  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;
  logic [31:0] head_word;
  logic [31:0] step_sum;
  logic [63:0] rot_wide;
  logic [5:0]  step_next;

  assign fill = msg_q[5:0];

  // Byte lane insert for the word being assembled.
  always_comb begin
    wbuf_d = wbuf_q;
    wbuf_d[8*fill[1:0] +: 8] = data_byte_i;
  end

  // Word holding the pad marker: bytes already taken, then 0x80, then zeros.
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (2'(l) < fill[1:0]) begin
        head_word[8*l +: 8] = wbuf_q[8*l +: 8];
      end else if (2'(l) == fill[1:0]) begin
        head_word[8*l +: 8] = PadByte;
      end else begin
        head_word[8*l +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill[5:2];
    ram_wdata = 32'h0;
    if (cmd_i.take_byte) begin
      ram_we    = 1'b1;
      ram_wdata = wbuf_d;
    end else if (cmd_i.pad_head) begin
      ram_we    = 1'b1;
      ram_wdata = head_word;
    end else if (cmd_i.pad_zero) begin
      ram_we    = 1'b1;
      ram_waddr = wcnt_q[3:0];
    end else if (cmd_i.len_lo) begin
      ram_we    = 1'b1;
      ram_waddr = LenLoWord;
      ram_wdata = {msg_q[28:0], 3'b000};
    end else if (cmd_i.len_hi) begin
      ram_we    = 1'b1;
      ram_waddr = LenHiWord;
      ram_wdata = msg_q[60:29];
    end
  end

  // The read address runs one step ahead to cover the registered read.
  assign step_next = cmd_i.cmp_load ? 6'd0 : 6'(step_q + 6'd1);
  assign ram_raddr = word_sel(step_next);

  md5sh_ram #(
    .Width(32),
    .Depth(16)
  ) u_block_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign step_sum = wa_q + round_fn(step_q[5:4], wb_q, wc_q, wd_q) + ram_rdata
                  + step_const(step_q);
  assign rot_wide = {step_sum, step_sum} << rot_amount(step_q);

  always_comb begin
    msg_d     = msg_q;
    wcnt_d    = wcnt_q;
    step_d    = step_q;
    chain_a_d = chain_a_q;
    chain_b_d = chain_b_q;
    chain_c_d = chain_c_q;
    chain_d_d = chain_d_q;
    wa_d      = wa_q;
    wb_d      = wb_q;
    wc_d      = wc_q;
    wd_d      = wd_q;

    if (cmd_i.take_byte) begin
      msg_d = msg_q + MsgCountWidth'(1);
    end

    if (cmd_i.wcnt_clr) begin
      wcnt_d = '0;
    end else if (cmd_i.pad_head) begin
      wcnt_d = WordCountWidth'({1'b0, fill[5:2]} + 5'd1);
    end else if (cmd_i.pad_zero || cmd_i.out_next) begin
      wcnt_d = wcnt_q + WordCountWidth'(1);
    end

    if (cmd_i.cmp_load) begin
      step_d = '0;
      wa_d   = chain_a_q;
      wb_d   = chain_b_q;
      wc_d   = chain_c_q;
      wd_d   = chain_d_q;
    end else if (cmd_i.cmp_step) begin
      step_d = step_q + 6'd1;
      wa_d   = wd_q;
      wd_d   = wc_q;
      wc_d   = wb_q;
      wb_d   = wb_q + rot_wide[63:32];
    end

    if (cmd_i.cmp_add) begin
      chain_a_d = chain_a_q + wa_q;
      chain_b_d = chain_b_q + wb_q;
      chain_c_d = chain_c_q + wc_q;
      chain_d_d = chain_d_q + wd_q;
    end

    if (cmd_i.finish) begin
      msg_d     = '0;
      chain_a_d = InitA;
      chain_b_d = InitB;
      chain_c_d = InitC;
      chain_d_d = InitD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_q     <= '0;
      wcnt_q    <= '0;
      step_q    <= '0;
      chain_a_q <= InitA;
      chain_b_q <= InitB;
      chain_c_q <= InitC;
      chain_d_q <= InitD;
    end else begin
      msg_q     <= msg_d;
      wcnt_q    <= wcnt_d;
      step_q    <= step_d;
      chain_a_q <= chain_a_d;
      chain_b_q <= chain_b_d;
      chain_c_q <= chain_c_d;
      chain_d_q <= chain_d_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte) begin
      wbuf_q <= wbuf_d;
    end
    wa_q <= wa_d;
    wb_q <= wb_d;
    wc_q <= wc_d;
    wd_q <= wd_d;
  end

  always_comb begin
    case (wcnt_q[1:0])
      2'd0:    digest_word_o = chain_a_q;
      2'd1:    digest_word_o = chain_b_q;
      2'd2:    digest_word_o = chain_c_q;
      2'd3:    digest_word_o = chain_d_q;
      default: digest_word_o = chain_a_q;
    endcase
  end

  assign word_index_o = wcnt_q[1:0];
  assign last_word_o  = (wcnt_q[1:0] == LastDigestWord);

  assign sts_o.fill      = fill;
  assign sts_o.wcnt      = wcnt_q;
  assign sts_o.step_last = (step_q == LastStep);

endmodule

/* hw/rtl/md5sh_ctrl.sv */
// Controller state machine of the MD5 stream hasher.
`timescale 1ns / 1ps

module md5sh_ctrl
  import md5sh_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    byte_present_i,
  input  logic    end_of_message_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  ret_e        ret_q, ret_d;
  logic        two_q, two_d;

  logic in_fire;
  logic out_fire;
  logic pad_done;

  assign in_fire  = in_valid_i && (state_q == ST_IDLE);
  assign out_fire = out_ready_i && (state_q == ST_OUT);
  assign pad_done = two_q ? (sts_i.wcnt == BlockWords) : (sts_i.wcnt == LenLoCount);

  // Next state.
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    two_d   = two_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (byte_present_i && (sts_i.fill == FullFill)) begin
            state_d = ST_CMP_LOAD;
            ret_d   = end_of_message_i ? RET_HEAD : RET_IDLE;
          end else if (end_of_message_i) begin
            state_d = ST_PAD_HEAD;
          end
        end
      end
      ST_PAD_HEAD: begin
        two_d   = (sts_i.fill > LastShortFill);
        state_d = ST_PAD_ZERO;
      end
      ST_PAD_ZERO: begin
        if (pad_done) begin
          if (two_q) begin
            state_d = ST_CMP_LOAD;
            ret_d   = RET_PAD2;
          end else begin
            state_d = ST_LEN_LO;
          end
        end
      end
      ST_LEN_LO: begin
        state_d = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        state_d = ST_CMP_LOAD;
        ret_d   = RET_OUT;
      end
      ST_CMP_LOAD: begin
        state_d = ST_CMP_STEP;
      end
      ST_CMP_STEP: begin
        if (sts_i.step_last) begin
          state_d = ST_CMP_ADD;
        end
      end
      ST_CMP_ADD: begin
        case (ret_q)
          RET_IDLE: state_d = ST_IDLE;
          RET_HEAD: state_d = ST_PAD_HEAD;
          RET_PAD2: begin
            state_d = ST_PAD_ZERO;
            two_d   = 1'b0;
          end
          RET_OUT:  state_d = ST_OUT;
          default:  state_d = ST_IDLE;
        endcase
      end
      ST_OUT: begin
        if (out_fire && (sts_i.wcnt[1:0] == LastDigestWord)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.take_byte = in_fire && byte_present_i;
      end
      ST_PAD_HEAD: cmd_o.pad_head = 1'b1;
      ST_PAD_ZERO: cmd_o.pad_zero = !pad_done;
      ST_LEN_LO:   cmd_o.len_lo = 1'b1;
      ST_LEN_HI:   cmd_o.len_hi = 1'b1;
      ST_CMP_LOAD: cmd_o.cmp_load = 1'b1;
      ST_CMP_STEP: cmd_o.cmp_step = 1'b1;
      ST_CMP_ADD: begin
        cmd_o.cmp_add  = 1'b1;
        cmd_o.wcnt_clr = 1'b1;
      end
      ST_OUT: begin
        out_valid_o    = 1'b1;
        cmd_o.out_next = out_fire;
        cmd_o.finish   = out_fire && (sts_i.wcnt[1:0] == LastDigestWord);
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= RET_IDLE;
      two_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      two_q   <= two_d;
    end
  end

endmodule

/* hw/rtl/md5_stream_hasher.sv */
// Top level of the MD5 stream hasher: byte stream in, four digest words out.
//
//   Channel   Direction  tdata              tuser              tlast
//   s_axis    in         data_byte [7:0]    byte_present       end_of_message
//   m_axis    out        digest_word [31:0] word_index [1:0]   last_word
//
// Transactions without end_of_message are taken one per cycle while idle.
// After the transaction that brings the sixty-fourth byte of a block, ready
// stays low while the shared round unit runs the 64 steps (a load state, one
// step per cycle, a state to fold into the chaining words).
// An end_of_message transaction costs the padding writes into the 16-word
// block RAM, one or two compressions and then four output transactions, one
// per cycle when the sink is ready.
// Reset is asynchronous and active low; it restores the initial vector and
// clears the byte count. The output holds its word while tready is low, and
// no input is taken until all four digest words have left.
`timescale 1ns / 1ps

module md5_stream_hasher
  import md5sh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] byte_present
  input  logic        s_axis_tlast_i,   // end_of_message
  // Digest stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic [1:0]  m_axis_tuser_o,   // [1:0] word_index
  output logic        m_axis_tlast_o    // last_word
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller sequences byte intake, padding, compression and output.
  md5sh_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .byte_present_i  (s_axis_tuser_i),
    .end_of_message_i(s_axis_tlast_i),
    .in_ready_o      (s_axis_tready_o),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  // The datapath holds the block words, the byte count and the MD5 state.
  md5sh_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .data_byte_i  (s_axis_tdata_i),
    .digest_word_o(m_axis_tdata_o),
    .word_index_o (m_axis_tuser_o),
    .last_word_o  (m_axis_tlast_o)
  );

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the MD5 stream hasher: directed table, then random messages.
`timescale 1ns / 1ps

module tb;

  localparam int NUM_DIRECTED = 22;
  localparam int RANDOM_ITEMS = 410;
  localparam int IDLE_PERCENT = 38;
  localparam int DRAIN_CYCLES = 200;

  // Digest of the empty message, word A in the lowest slot.
  localparam logic [3:0][31:0] EMPTY_DIGEST = {
    32'h7e42f8ec, 32'h980980e9, 32'h04b2008f, 32'hd98c1dd4
  };

  typedef struct packed {
    logic [7:0]       data;
    logic             present;
    logic             eom;
    logic             known;
    logic [3:0][31:0] digest;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        last;
  } digest_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;  // [7:0] data_byte
  logic        s_axis_tuser_i = 1'b0;   // [0] byte_present
  logic        s_axis_tlast_i = 1'b0;   // end_of_message
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;          // [31:0] digest_word
  logic [1:0]  m_axis_tuser_o;          // [1:0] word_index
  logic        m_axis_tlast_o;          // last_word

  md5_stream_hasher DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Sine-derived additive constants of the 64 steps.
  logic [31:0] round_k [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Left-rotate amounts, four per round.
  int shift_tab [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  // Lengths around the padding boundaries: one versus two final blocks.
  int boundary_len [10] = '{54, 55, 56, 57, 63, 64, 65, 119, 120, 128};

  // Directed items. Only the empty message carries a typed-in digest; every
  // other row is checked against the running hash below.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message right after reset
    '{8'h5a, 1'b0, 1'b0, 1'b0, '0},            // neither byte nor end: ignored
    '{8'h61, 1'b1, 1'b1, 1'b0, '0},            // one byte closed in the same item
    '{8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{8'hff, 1'b1, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, 1'b0, '0},
    '{8'h7f, 1'b1, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, 1'b0, '0},            // ignored, data must not leak in
    '{8'h00, 1'b0, 1'b1, 1'b0, '0},            // end without a byte
    '{8'hc3, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},  // empty message right after a digest
    '{8'hff, 1'b1, 1'b1, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, 1'b0, '0},
    '{8'h61, 1'b1, 1'b0, 1'b0, '0},
    '{8'h62, 1'b1, 1'b0, 1'b0, '0},
    '{8'h63, 1'b1, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h55, 1'b1, 1'b0, 1'b0, '0},
    '{8'haa, 1'b1, 1'b0, 1'b0, '0},
    '{8'h01, 1'b1, 1'b0, 1'b0, '0},
    '{8'hfe, 1'b1, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b1, 1'b0, '0}
  };

  // Running hash state mirrored from the block.
  logic [31:0] hash_st [4];
  logic [31:0] hash_out [4];
  logic [7:0]  blk_bytes [64];
  logic [60:0] msg_len;

  digest_beat_t digest_q [$];
  int           mismatch_cnt = 0;
  int           item_count = 0;
  logic         no_idle = 1'b0;

  function automatic void hash_reset();
    hash_st[0] = md5sh_pkg::InitA;
    hash_st[1] = md5sh_pkg::InitB;
    hash_st[2] = md5sh_pkg::InitC;
    hash_st[3] = md5sh_pkg::InitD;
    msg_len    = '0;
  endfunction

  // One 64-step compression of blk_bytes into the chaining words.
  function automatic void md5_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t, sum;
    int          i, g, rnd, s;
    for (i = 0; i < 16; i++) begin
      w[i] = {blk_bytes[4*i+3], blk_bytes[4*i+2], blk_bytes[4*i+1], blk_bytes[4*i]};
    end
    a = hash_st[0];
    b = hash_st[1];
    c = hash_st[2];
    d = hash_st[3];
    for (i = 0; i < 64; i++) begin
      rnd = i / 16;
      case (rnd)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      s   = shift_tab[rnd * 4 + i % 4];
      sum = a + f + w[g] + round_k[i];
      t   = d;
      d   = c;
      c   = b;
      b   = b + ((sum << s) | (sum >> (32 - s)));
      a   = t;
    end
    hash_st[0] += a;
    hash_st[1] += b;
    hash_st[2] += c;
    hash_st[3] += d;
  endfunction

  // Absorbs one item; returns 1 and fills hash_out when the message closes.
  function automatic bit md5_absorb(input logic [7:0] dbyte, input logic present,
                                    input logic eom);
    int          fill, j;
    logic [63:0] bit_len;
    if (present) begin
      fill = msg_len[5:0];
      blk_bytes[fill] = dbyte;
      msg_len = msg_len + 61'd1;
      if (fill == 63) md5_compress();
    end
    if (!eom) return 1'b0;
    fill = msg_len[5:0];
    blk_bytes[fill] = 8'h80;
    for (j = fill + 1; j < 64; j++) blk_bytes[j] = 8'h00;
    // No room left for the length: it goes into a second, extra block.
    if (fill > 55) begin
      md5_compress();
      for (j = 0; j < 56; j++) blk_bytes[j] = 8'h00;
    end
    bit_len = {msg_len, 3'b000};
    for (j = 0; j < 8; j++) blk_bytes[56 + j] = bit_len[8*j +: 8];
    md5_compress();
    for (j = 0; j < 4; j++) hash_out[j] = hash_st[j];
    hash_reset();
    return 1'b1;
  endfunction

  // Drives one input transaction, waits for acceptance, then records the
  // digest words the block owes for it.
  task automatic send_item(input logic [7:0] dbyte, input logic present, input logic eom,
                           input logic known, input logic [3:0][31:0] known_digest);
    int k;
    if (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= dbyte;
    s_axis_tuser_i  <= present;
    s_axis_tlast_i  <= eom;
    do @(posedge clk_i); while (!s_axis_tready_o);
    item_count++;
    if (md5_absorb(dbyte, present, eom)) begin
      for (k = 0; k < 4; k++) begin
        digest_q.push_back('{known ? known_digest[k] : hash_out[k], 2'(k), k == 3});
      end
    end
  endtask

  // A random message of n_bytes, with stray empty items mixed in. The final
  // byte rides on the closing item about half of the time.
  task automatic send_message(input int n_bytes);
    bit tail_end;
    int k;
    tail_end = (n_bytes > 0) && ($urandom_range(1) == 1);
    for (k = 0; k < n_bytes; k++) begin
      if ($urandom_range(19) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, '0);
      send_item(8'($urandom_range(255)), 1'b1, tail_end && (k == n_bytes - 1), 1'b0, '0);
    end
    if (!tail_end) send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, '0);
  endtask

  // Digest sink with random back-pressure.
  always @(posedge clk_i) begin
    m_axis_tready_i <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // Every accepted digest word is compared with the oldest one still owed.
  always @(posedge clk_i) begin
    digest_beat_t exp_beat;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word %h index %0d last %0b", $time,
                 m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        mismatch_cnt++;
      end else begin
        exp_beat = digest_q.pop_front();
        if (m_axis_tdata_o !== exp_beat.word) begin
          $display("%0t: digest word expected %h actual %h", $time, exp_beat.word,
                   m_axis_tdata_o);
          mismatch_cnt++;
        end
        if (m_axis_tuser_o !== exp_beat.idx) begin
          $display("%0t: word index expected %0d actual %0d", $time, exp_beat.idx,
                   m_axis_tuser_o);
          mismatch_cnt++;
        end
        if (m_axis_tlast_o !== exp_beat.last) begin
          $display("%0t: last word expected %0b actual %0b", $time, exp_beat.last,
                   m_axis_tlast_o);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    int r;
    hash_reset();
    foreach (blk_bytes[j]) blk_bytes[j] = 8'h00;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < NUM_DIRECTED; r++) begin
      send_item(directed_rows[r].data, directed_rows[r].present, directed_rows[r].eom,
                directed_rows[r].known, directed_rows[r].digest);
    end

    // Mostly short messages, a good share sitting on the padding boundaries,
    // and some of any length up to a few blocks.
    while (item_count < NUM_DIRECTED + RANDOM_ITEMS) begin
      no_idle <= (item_count >= 200) && (item_count < 300);
      r = $urandom_range(99);
      if (r < 50) send_message($urandom_range(12));
      else if (r < 80) send_message(boundary_len[$urandom_range(9)]);
      else send_message($urandom_range(130));
    end
    s_axis_tvalid_i <= 1'b0;

    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("md5_stream_hasher: match");
    end else begin
      $display("md5_stream_hasher: mismatch");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("md5_stream_hasher: mismatch");
    $finish;
  end

endmodule
